// File: rtl/ilir_pkg.sv
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and codes for the indexed list engine: transaction payloads,
// operation and status codes, and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
package ilir_pkg;

    // operation codes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // fixed field widths
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int CNT_W = 7;

    // command transaction
    typedef struct packed {
        logic [1:0]       operation;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] item_value;
    } in_t;

    // result transaction
    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [1:0]       status;
        logic [CNT_W-1:0] entry_count;
    } out_t;

    // control word broadcast along the cell row
    typedef struct packed {
        logic insert;
        logic remove;
        logic read;
    } ctl_t;

endpackage

// File: rtl/ilir_cell.sv
// ----------------------------------------------------------------------------
// ilir_cell
// One list slot. On insert it loads the new value at the index and takes its
// left neighbor's entry above it; on remove it takes its right neighbor's
// entry at or above the index. It also drives its entry onto the read bus on a read hit.
// ----------------------------------------------------------------------------
module ilir_cell
    import ilir_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int CW    = 7,
    parameter int INDEX = 0
)
(
    input  logic             clk,
    input  ctl_t             ctl,
    input  logic [CW-1:0]    pos,
    input  logic [WIDTH-1:0] value,
    input  logic [WIDTH-1:0] left,
    input  logic [WIDTH-1:0] right,
    output logic [WIDTH-1:0] entry,
    output logic [WIDTH-1:0] rd_data
);

    localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

    logic [WIDTH-1:0] entry_reg;
    logic [WIDTH-1:0] entry_next;
    logic             hit;
    logic             above;

    assign hit   = (pos == MY_IDX);
    assign above = (MY_IDX > pos);

    // slot update
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.insert)
        begin
            if (hit)
            begin
                entry_next = value;
            end
            else if (above)
            begin
                entry_next = left;
            end
        end
        else if (ctl.remove)
        begin
            if (hit || above)
            begin
                entry_next = right;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // read bus contribution
    assign entry   = entry_reg;
    assign rd_data = (ctl.read && hit) ? entry_reg : '0;

endmodule

// File: rtl/ilir_ctrl.sv
// ----------------------------------------------------------------------------
// ilir_ctrl
// Holds the entry count, checks each command against it and issues the
// control word and effective index to the cell row.
// ----------------------------------------------------------------------------
module ilir_ctrl
    import ilir_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int CNTW  = 7,
    parameter int CW    = 7
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [1:0]      operation,
    input  logic [POS_W-1:0] position,
    output ctl_t            ctl,
    output logic [CW-1:0]   eff_pos,
    output logic [1:0]      status,
    output logic [CNTW-1:0] count,
    output logic [CNTW-1:0] count_upd
);

    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic [CW-1:0]   pos_ext;
    logic [CW-1:0]   cnt_ext;
    logic            full;

    assign pos_ext = CW'(position);
    assign cnt_ext = CW'(count_reg);
    assign full    = (count_reg == FULL_CNT);

    // command decode and range checks
    always_comb
    begin
        ctl        = '0;
        eff_pos    = pos_ext;
        status     = ST_OK;
        count_next = count_reg;
        unique case (operation)
            OP_APPEND:
            begin
                eff_pos = cnt_ext;
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctl.insert = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_INSERT:
            begin
                if (pos_ext > cnt_ext)
                begin
                    status = ST_RANGE;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctl.insert = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    ctl.remove = accept;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    ctl.read = accept;
                end
            end
        endcase
    end

    // entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    assign count     = count_reg;
    assign count_upd = count_next;

endmodule

// File: rtl/indexed_list_insert_remove.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// Ordered list of up to DEPTH entries held in a row of cells, with append,
// insert, remove and read by index.
// ----------------------------------------------------------------------------
// A command is taken on every clock edge where start is high; busy is never
// raised, so one transaction per cycle is sustained. Insert and remove move
// every later entry by one slot at once, since each cell loads from its
// neighbor in parallel. The result appears on the next cycle with done
// high for exactly that one cycle and must be captured then: there is no way
// to stall it. A later command sees the list as left by every earlier one.
// Slots start undefined and need no clearing after reset; only the count is
// reset. A failed command leaves the list unchanged.
module indexed_list_insert_remove
    import ilir_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  cmd,
    output logic done,
    output out_t result
);

    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int CW   = (CNTW > POS_W) ? CNTW : POS_W;

    logic             accept;
    ctl_t             ctl;
    logic [CW-1:0]    eff_pos;
    logic [1:0]       status;
    logic [CNTW-1:0]  count;
    logic [CNTW-1:0]  count_upd;
    logic [WIDTH-1:0] wval;
    logic [WIDTH-1:0] entries [DEPTH];
    logic [WIDTH-1:0] rd_bits [DEPTH];
    logic [WIDTH-1:0] rd_or;
    logic [VAL_W-1:0] rd_val;
    logic             done_reg;
    out_t             result_reg;
    out_t             result_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // command checks and count
    ilir_ctrl #(
        .DEPTH (DEPTH),
        .CNTW  (CNTW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (cmd.operation),
        .position  (cmd.position),
        .ctl       (ctl),
        .eff_pos   (eff_pos),
        .status    (status),
        .count     (count),
        .count_upd (count_upd)
    );

    // value fitted to the entry width
    generate
        if (WIDTH <= VAL_W)
        begin : g_val_narrow
            assign wval = cmd.item_value[WIDTH-1:0];
        end
        else
        begin : g_val_wide
            assign wval = {{(WIDTH-VAL_W){1'b0}}, cmd.item_value};
        end
    endgenerate

    // row of cells
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [WIDTH-1:0] left_w;
            logic [WIDTH-1:0] right_w;
            if (gi == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_inner_l
                assign left_w = entries[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_w = entries[gi];
            end
            else
            begin : g_inner_r
                assign right_w = entries[gi+1];
            end
            ilir_cell #(
                .WIDTH (WIDTH),
                .CW    (CW),
                .INDEX (gi)
            ) u_cell (
                .clk     (clk),
                .ctl     (ctl),
                .pos     (eff_pos),
                .value   (wval),
                .left    (left_w),
                .right   (right_w),
                .entry   (entries[gi]),
                .rd_data (rd_bits[gi])
            );
        end
    endgenerate

    // read bus: at most one cell drives a nonzero word
    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_or = rd_or | rd_bits[i];
        end
    end

    generate
        if (WIDTH >= VAL_W)
        begin : g_rd_wide
            assign rd_val = rd_or[VAL_W-1:0];
        end
        else
        begin : g_rd_narrow
            assign rd_val = {{(VAL_W-WIDTH){1'b0}}, rd_or};
        end
    endgenerate

    // result register
    always_comb
    begin
        result_next.read_value  = rd_val;
        result_next.status      = status;
        result_next.entry_count = CNT_W'(count_upd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result missing after accepted transaction");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNTW'(DEPTH))
        else $error("entry count above capacity");

    a_fail_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_OK)) |-> (count == $past(count)))
        else $error("failed transaction changed the count");

    a_ctl_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.insert, ctl.remove, ctl.read}))
        else $error("more than one cell command at once");

endmodule
